[rtl/core/mcsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcsp_pkg
// Shared types, constants and conversions for the servo pulse sequencer.
// ----------------------------------------------------------------------------
package mcsp_pkg;

  localparam int CHANNELS  = 12;
  localparam int CLOCK_MHZ = 16;

  localparam int MIN_US      = 544;
  localparam int MAX_US      = 2400;
  localparam int DEFAULT_US  = 1500;
  localparam int REFRESH_US  = 25000;
  localparam int TRIM_US     = 2;
  localparam int SLACK_TICKS = 4;
  localparam int PRESCALE    = 8;

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int CUR_W  = CH_W + 1;
  localparam int TICK_W = 13;
  localparam int CNT_W  = 16;
  localparam int US_W   = 16;
  localparam int RD_W   = 12;
  localparam int CIU_W  = 4;

  localparam int DEFAULT_TICKS = CLOCK_MHZ * DEFAULT_US / PRESCALE;
  localparam int REFRESH_TICKS = (CLOCK_MHZ * REFRESH_US / PRESCALE) % 65536;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_WIDTH  = 2'd1,
    OP_ACTIVE = 2'd2,
    OP_START  = 2'd3
  } op_t;

  typedef struct packed {
    logic              active;
    logic [TICK_W-1:0] ticks;
  } chan_word_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr;
    chan_word_t      word;
  } chan_wr_t;

  typedef struct packed {
    logic            en;
    logic [CH_W-1:0] addr_a;
    logic [CH_W-1:0] addr_b;
  } chan_rd_t;

  // clamp, trim, scale to prescaled timer ticks
  function automatic logic [TICK_W-1:0] us_to_ticks(input logic [US_W-1:0] us);
    logic [US_W-1:0] c;
    logic [US_W+7:0] prod;
    begin
      c = us;
      if (c < US_W'(MIN_US)) c = US_W'(MIN_US);
      if (c > US_W'(MAX_US)) c = US_W'(MAX_US);
      c = c - US_W'(TRIM_US);
      prod = (US_W+8)'(c) * (US_W+8)'(CLOCK_MHZ);
      prod = prod / (US_W+8)'(PRESCALE);
      return prod[TICK_W-1:0];
    end
  endfunction

  // ticks back to microseconds plus trim
  function automatic logic [RD_W-1:0] ticks_to_us(input logic [TICK_W-1:0] ticks);
    logic [TICK_W+3:0] prod;
    begin
      prod = (TICK_W+4)'(ticks) * (TICK_W+4)'(PRESCALE);
      prod = prod / (TICK_W+4)'(CLOCK_MHZ);
      prod = prod + (TICK_W+4)'(TRIM_US);
      return prod[RD_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/multi_channel_servo_pulse_sequencer_top.sv]
`default_nettype none
// An accepted beat is registered in stage 1, then in the output register.
// Throughput: one beat per cycle unless out_stall holds it; the channel memory
//   is read at accept, written on leaving stage 1, same-edge writes forwarded.
// Reset (rst, sync, active high): widths read as 1502 us through valid bits,
//   all channels detached, timer stopped, start pending, no channels in use.
// ----------------------------------------------------------------------------
// multi_channel_servo_pulse_sequencer_top
// RC servo pulse train generator: steps channel by channel on compare
// matches of a prescaled tick counter, then waits out the refresh frame.
// ----------------------------------------------------------------------------
module multi_channel_servo_pulse_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [3:0]  channel,
  input  wire logic [15:0] width_us,
  input  wire logic        active_value,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      pin_levels,
  output logic             needs_start,
  output logic             timer_running,
  output logic [11:0]      read_width_us,
  output logic             channel_active
);

  localparam int CH  = mcsp_pkg::CHANNELS;
  localparam int CHW = mcsp_pkg::CH_W;
  localparam int CUW = mcsp_pkg::CUR_W;
  localparam int CNW = mcsp_pkg::CNT_W;

  // ---- configuration --------------------------------------------------------
  logic [mcsp_pkg::CIU_W-1:0] ciu;

  always_ff @(posedge clk) begin
    if (rst) begin
      ciu <= '0;
    end else if (cfg_wr_en) begin
      ciu <= cfg_wr_data;
    end
  end

  // ---- sequencer state ------------------------------------------------------
  // cursor: idle flag plus index of the channel whose pulse is high.
  // cur_active mirrors the active flag of that channel so the falling edge
  // needs no extra memory port.
  logic           idle, idle_next;
  logic [CHW-1:0] cur, cur_next;
  logic           cur_active, cur_active_next;
  logic [CH-1:0]  levels, levels_next;
  logic [CNW-1:0] tick, tick_next;
  logic [CNW-1:0] compare, compare_next;
  logic           counting, counting_next;
  logic           pending, pending_next;

  // ---- stage 1 (memory data returns here) -----------------------------------
  logic                   s1_valid;
  mcsp_pkg::op_t          s1_op;
  logic [3:0]             s1_ch;
  logic [15:0]            s1_us;
  logic                   s1_act;
  logic                   s1_fire;
  logic                   in_fire;
  logic                   out_free;

  mcsp_pkg::chan_rd_t     rd;
  mcsp_pkg::chan_wr_t     wr;
  mcsp_pkg::chan_word_t   word_a;   // addressed channel
  mcsp_pkg::chan_word_t   word_b;   // channel after the cursor

  logic                   ch_ok;
  logic                   adv;
  logic                   adv_start;
  logic [CUW-1:0]         nxt;
  logic [CNW:0]           slack_sum;
  logic [CUW-1:0]         pre_nxt;
  logic [mcsp_pkg::TICK_W-1:0] rd_ticks;
  logic [mcsp_pkg::RD_W-1:0]   rd_us;
  logic                   rd_active;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  mcsp_chan_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .wr     (wr),
    .word_a (word_a),
    .word_b (word_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op  <= mcsp_pkg::op_t'(opcode);
      s1_ch  <= channel;
      s1_us  <= width_us;
      s1_act <= active_value;
    end
  end

  // Read addresses come from the state as it will stand after the item now
  // leaving stage 1, so back-to-back advances see the right channel.
  always_comb begin
    pre_nxt   = idle_next ? '0 : (CUW'(cur_next) + CUW'(1));
    rd.en     = in_fire;
    rd.addr_a = (channel < 4'(CH)) ? channel[CHW-1:0] : '0;
    rd.addr_b = (pre_nxt < CUW'(CH)) ? pre_nxt[CHW-1:0] : '0;
  end

  // ---- item processing ------------------------------------------------------
  always_comb begin
    idle_next       = idle;
    cur_next        = cur;
    cur_active_next = cur_active;
    levels_next     = levels;
    tick_next       = tick;
    compare_next    = compare;
    counting_next   = counting;
    pending_next    = pending;
    wr.en           = 1'b0;
    wr.addr         = s1_ch[CHW-1:0];
    wr.word         = word_a;
    adv             = 1'b0;
    adv_start       = 1'b0;
    nxt             = '0;
    slack_sum       = '0;
    ch_ok           = s1_ch < 4'(CH);

    if (s1_fire) begin
      case (s1_op)
        mcsp_pkg::OP_TICK: begin
          if (counting) begin
            tick_next = tick + CNW'(1);
            adv       = (tick_next == compare);
          end
        end
        mcsp_pkg::OP_WIDTH: begin
          if (ch_ok) begin
            wr.en         = 1'b1;
            wr.word.ticks = mcsp_pkg::us_to_ticks(s1_us);
          end
        end
        mcsp_pkg::OP_ACTIVE: begin
          if (ch_ok) begin
            wr.en          = 1'b1;
            wr.word.active = s1_act;
            if (!idle && (s1_ch[CHW-1:0] == cur)) begin
              cur_active_next = s1_act;
            end
          end
        end
        mcsp_pkg::OP_START: begin
          adv       = 1'b1;
          adv_start = 1'b1;
        end
        default: begin
        end
      endcase

      if (adv) begin
        if (idle && !adv_start) begin
          // match with no train: stop and ask for a start
          pending_next  = 1'b1;
          counting_next = 1'b0;
        end else begin
          if (idle) begin
            tick_next     = '0;
            counting_next = 1'b1;
            nxt           = '0;
          end else begin
            // end of current pulse (detached channels keep their level)
            if ((cur < ciu) && cur_active) begin
              levels_next[cur] = 1'b0;
            end
            nxt = CUW'(cur) + CUW'(1);
          end
          if ((nxt < CUW'(ciu)) && (nxt < CUW'(CH))) begin
            compare_next    = tick_next + CNW'(word_b.ticks);
            cur_next        = nxt[CHW-1:0];
            idle_next       = 1'b0;
            cur_active_next = word_b.active;
            if (word_b.active) begin
              levels_next[nxt[CHW-1:0]] = 1'b1;
            end
          end else begin
            // last channel done: wait for the refresh point
            slack_sum = (CNW+1)'(tick_next) + (CNW+1)'(mcsp_pkg::SLACK_TICKS);
            if (slack_sum < (CNW+1)'(mcsp_pkg::REFRESH_TICKS)) begin
              compare_next = CNW'(mcsp_pkg::REFRESH_TICKS);
            end else begin
              compare_next = slack_sum[CNW-1:0];
            end
            idle_next = 1'b1;
          end
        end
        if (adv_start) begin
          pending_next = 1'b0;
        end
      end
    end
  end

  // readback reflects this item's own write
  always_comb begin
    rd_ticks  = (s1_op == mcsp_pkg::OP_WIDTH) ? mcsp_pkg::us_to_ticks(s1_us) : word_a.ticks;
    rd_active = (s1_op == mcsp_pkg::OP_ACTIVE) ? s1_act : word_a.active;
    rd_us     = mcsp_pkg::ticks_to_us(rd_ticks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle       <= 1'b1;
      cur        <= '0;
      cur_active <= 1'b0;
      levels     <= '0;
      tick       <= '0;
      compare    <= '0;
      counting   <= 1'b0;
      pending    <= 1'b1;
    end else begin
      idle       <= idle_next;
      cur        <= cur_next;
      cur_active <= cur_active_next;
      levels     <= levels_next;
      tick       <= tick_next;
      compare    <= compare_next;
      counting   <= counting_next;
      pending    <= pending_next;
    end
  end

  // ---- output register ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pin_levels     <= 12'(levels_next);
      needs_start    <= pending_next;
      timer_running  <= counting_next;
      read_width_us  <= ch_ok ? rd_us : '0;
      channel_active <= ch_ok && rd_active;
    end
  end

endmodule
`default_nettype wire

[rtl/core/mcsp_chan_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mcsp_chan_store
// Per-channel width/active memory: two registered read ports, one write
// port, same-edge write forwarding, valid bits for the reset default.
// ----------------------------------------------------------------------------
module mcsp_chan_store (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mcsp_pkg::chan_rd_t   rd,
  input  wire mcsp_pkg::chan_wr_t   wr,
  output mcsp_pkg::chan_word_t      word_a,
  output mcsp_pkg::chan_word_t      word_b
);

  mcsp_pkg::chan_word_t mem [mcsp_pkg::CHANNELS];
  logic [mcsp_pkg::CHANNELS-1:0] vld;

  mcsp_pkg::chan_word_t mem_a;
  mcsp_pkg::chan_word_t mem_b;
  mcsp_pkg::chan_word_t fwd;
  logic vld_a;
  logic vld_b;
  logic hit_a;
  logic hit_b;
  mcsp_pkg::chan_word_t dflt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      mem_a <= mem[rd.addr_a];
      mem_b <= mem[rd.addr_b];
      fwd   <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        vld_a <= vld[rd.addr_a];
        vld_b <= vld[rd.addr_b];
        // read-before-write on a same-edge hit: take the written word
        hit_a <= wr.en && (wr.addr == rd.addr_a);
        hit_b <= wr.en && (wr.addr == rd.addr_b);
      end
    end
  end

  always_comb begin
    dflt.active = 1'b0;
    dflt.ticks  = mcsp_pkg::TICK_W'(mcsp_pkg::DEFAULT_TICKS);
    word_a = hit_a ? fwd : (vld_a ? mem_a : dflt);
    word_b = hit_b ? fwd : (vld_b ? mem_b : dflt);
  end

endmodule
`default_nettype wire
